/* hdl/sbeq_pkg.sv */
`default_nettype none
// ============================================================================
// sbeq_pkg - shared types and constants for the stereo biquad equalizer
// Field widths, command and coefficient codes, Q-format constants and the
// row and control types passed between the sequencer, stores and MAC unit.
// ============================================================================
package sbeq_pkg;

    localparam int CMD_W        = 2;
    localparam int SAMPLE_W     = 24;
    localparam int COEF_W       = 25;
    localparam int BAND_FIELD_W = 4;
    localparam int SEL_W        = 3;

    localparam int COEF_PER_BAND = 5;
    localparam int TERM_W        = 3;

    // exact product and sum of five products
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + 4;

    localparam int FRAC_SHIFT = 22;
    localparam int RND_HALF   = 2097152;
    localparam int COEF_ONE   = 4194304;
    localparam int SAMPLE_MAX = 8388607;
    localparam int SAMPLE_MIN = -8388608;

    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COEF  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [SEL_W-1:0] SEL_B0 = 3'd0;
    localparam logic [SEL_W-1:0] SEL_B1 = 3'd1;
    localparam logic [SEL_W-1:0] SEL_B2 = 3'd2;
    localparam logic [SEL_W-1:0] SEL_A1 = 3'd3;
    localparam logic [SEL_W-1:0] SEL_A2 = 3'd4;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef t_coef [COEF_PER_BAND-1:0]  t_coef_row;

    // one history row: one section of one channel
    typedef struct packed {
        t_sample x1;
        t_sample x2;
        t_sample y1;
        t_sample y2;
    } t_hist_row;

    typedef struct packed {
        logic  init;
        logic  en;
        logic  [SEL_W-1:0] sel;
        t_coef data;
    } t_coef_wr;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic neg;
    } t_mac_ctl;

endpackage : sbeq_pkg
`default_nettype wire

/* hdl/sbeq_if.sv */
`default_nettype none
// ============================================================================
// sbeq_if - valid/ready channels of the stereo biquad equalizer
// Input channel carries commands and frames; output channel carries the
// filtered stereo frame.
// ============================================================================
interface sbeq_in_if import sbeq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    t_sample                  left_in;
    t_sample                  right_in;
    logic [BAND_FIELD_W-1:0]  band;
    logic [SEL_W-1:0]         coef_select;
    t_coef                    coef_value;

    modport source (
        output valid, cmd, left_in, right_in, band, coef_select, coef_value,
        input  ready
    );
    modport sink (
        input  valid, cmd, left_in, right_in, band, coef_select, coef_value,
        output ready
    );
endinterface : sbeq_in_if

interface sbeq_out_if import sbeq_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample left_out;
    t_sample right_out;

    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input  valid, left_out, right_out, output ready);
endinterface : sbeq_out_if
`default_nettype wire

/* hdl/sbeq_coef_ram.sv */
`default_nettype none
// ============================================================================
// sbeq_coef_ram - per-band coefficient store
// Five lanes (b0, b1, b2, a1, a2), one row per band, registered row read.
// ============================================================================
module sbeq_coef_ram import sbeq_pkg::*; #(
    parameter int NUM_BANDS = 15,
    parameter int BAND_W    = 4
) (
    input  wire logic              i_clk,
    input  wire t_coef_wr          i_wr,
    input  wire logic [BAND_W-1:0] i_wr_addr,
    input  wire logic              i_rd_en,
    input  wire logic [BAND_W-1:0] i_rd_addr,
    output      t_coef_row         o_rd_row
);

    t_coef     r_mem [COEF_PER_BAND][NUM_BANDS];
    t_coef_row r_rd_row;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < COEF_PER_BAND; l++) begin
            if (i_wr.init) begin
                // pass-through section: b0 one, the rest zero
                r_mem[l][i_wr_addr] <= (l == 0) ? COEF_W'(COEF_ONE) : '0;
            end else if (i_wr.en && (i_wr.sel == SEL_W'(l))) begin
                r_mem[l][i_wr_addr] <= i_wr.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            for (int l = 0; l < COEF_PER_BAND; l++) begin
                r_rd_row[l] <= r_mem[l][i_rd_addr];
            end
        end
    end

    assign o_rd_row = r_rd_row;

endmodule : sbeq_coef_ram
`default_nettype wire

/* hdl/sbeq_hist_ram.sv */
`default_nettype none
// ============================================================================
// sbeq_hist_ram - filter history store
// One row of x1, x2, y1, y2 per section and channel; one write and one
// registered read per cycle.
// ============================================================================
module sbeq_hist_ram import sbeq_pkg::*; #(
    parameter int DEPTH  = 30,
    parameter int ADDR_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire t_hist_row         i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      t_hist_row         o_rdata
);

    t_hist_row r_mem [DEPTH];
    t_hist_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : sbeq_hist_ram
`default_nettype wire

/* hdl/sbeq_mac.sv */
`default_nettype none
// ============================================================================
// sbeq_mac - shared multiply-accumulate unit
// Multiply, accumulate (add or subtract), then round to Q1.23 and saturate.
// Three register stages from a term to the section output.
// ============================================================================
module sbeq_mac import sbeq_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mac_ctl i_ctl,
    input  wire t_coef    i_coef,
    input  wire t_sample  i_data,
    output      logic     o_y_vld,
    output      t_sample  o_y
);

    localparam logic signed [ACC_W-1:0] ACC_SMAX = ACC_W'(SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] ACC_SMIN = ACC_W'(SAMPLE_MIN);
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(RND_HALF);

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_p_vld;
    logic                     r_p_first;
    logic                     r_p_last;
    logic                     r_p_neg;

    logic signed [ACC_W-1:0]  w_ext;
    logic signed [ACC_W-1:0]  w_term;
    logic signed [ACC_W-1:0]  w_base;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_a_vld;
    logic                     r_a_last;

    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]  w_q;
    t_sample                  w_sat;
    t_sample                  r_y;
    logic                     r_y_vld;

    assign w_prod = PROD_W'(i_coef) * PROD_W'(i_data);
    assign w_ext  = ACC_W'(r_prod);
    assign w_term = r_p_neg ? -w_ext : w_ext;
    assign w_base = r_p_first ? '0 : r_acc;

    // add half an LSB, floor shift, clamp
    assign w_rnd = r_acc + ACC_HALF;
    assign w_q   = w_rnd >>> FRAC_SHIFT;

    always_comb begin
        if (w_q > ACC_SMAX) begin
            w_sat = SAMPLE_W'(SAMPLE_MAX);
        end else if (w_q < ACC_SMIN) begin
            w_sat = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            w_sat = w_q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_a_vld <= 1'b0;
            r_y_vld <= 1'b0;
        end else begin
            r_p_vld <= i_ctl.vld;
            r_a_vld <= r_p_vld;
            r_y_vld <= r_a_vld && r_a_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod    <= w_prod;
        r_p_first <= i_ctl.first;
        r_p_last  <= i_ctl.last;
        r_p_neg   <= i_ctl.neg;
        if (r_p_vld) begin
            r_acc <= w_base + w_term;
        end
        r_a_last <= r_p_last;
        r_y      <= w_sat;
    end

    assign o_y_vld = r_y_vld;
    assign o_y     = r_y;

endmodule : sbeq_mac
`default_nettype wire

/* hdl/stereo_biquad_cascade_equalizer.sv */
`default_nettype none
// ============================================================================
// stereo_biquad_cascade_equalizer - stereo cascaded biquad equalizer
// Sequencer that runs a cascade of direct-form-I biquad sections over both
// channels of a frame on one shared multiply-accumulate unit.
// ============================================================================
//
//  channel   dir  beat contents                              results
//  --------  ---  -----------------------------------------  ---------------
//  i_in      in   cmd, left_in, right_in, band,              frame: one beat
//                 coef_select, coef_value                    others: none
//  o_out     out  left_out, right_out                        -
//  i_cfg_*   in   enable (write only)                        -
//
//  Work: an enabled frame runs the sections band by band, left channel then
//  right; each section and channel costs one store read and five MAC terms,
//  then waits for the MAC result. A disabled frame skips the sections, and
//  a history clear sweeps the history store to zero.
//  Reset: after reset the block sweeps both stores (coefficients to
//  pass-through, history to zero) with i_in.ready low.
//  Stalls: o_out is a register; the next beat is accepted while a result
//  waits, and a new frame holds in its final cycle until o_out frees up.
//
module stereo_biquad_cascade_equalizer import sbeq_pkg::*; #(
    parameter int NUM_BANDS = 15
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    sbeq_in_if.sink   i_in,
    sbeq_out_if.source o_out
);

    localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int HROWS  = 2 * NUM_BANDS;
    localparam int HROW_W = $clog2(HROWS);

    localparam logic [BAND_W-1:0] LAST_BAND  = BAND_W'(NUM_BANDS - 1);
    localparam logic [HROW_W-1:0] LAST_HROW  = HROW_W'(HROWS - 1);
    localparam logic [HROW_W-1:0] HROW_RIGHT = HROW_W'(NUM_BANDS);
    localparam logic [TERM_W-1:0] TERM_LAST  = TERM_W'(COEF_PER_BAND - 1);
    localparam logic [TERM_W-1:0] TERM_X     = 3'd0;
    localparam logic [TERM_W-1:0] TERM_X1    = 3'd1;
    localparam logic [TERM_W-1:0] TERM_X2    = 3'd2;
    localparam logic [TERM_W-1:0] TERM_Y1    = 3'd3;

    localparam logic [2:0] ST_SWEEP = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_MAC   = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // control state
    logic [2:0]        r_state,      n_state;
    logic [HROW_W-1:0] r_sweep_cnt,  n_sweep_cnt;
    logic              r_sweep_coef, n_sweep_coef;
    logic [BAND_W-1:0] r_band,       n_band;
    logic              r_ch,         n_ch;
    logic [TERM_W-1:0] r_term,       n_term;
    logic              r_enable;
    logic              r_out_vld,    n_out_vld;

    // payload
    t_sample r_smp [2];
    t_sample r_out_l;
    t_sample r_out_r;

    logic              w_accept;
    logic              w_out_load;
    logic              w_sec_done;
    logic [HROW_W-1:0] w_hrow;

    t_coef_wr          w_coef_wr;
    logic [BAND_W-1:0] w_coef_waddr;
    t_coef_row         w_coef_row;

    logic              w_hist_we;
    logic [HROW_W-1:0] w_hist_waddr;
    t_hist_row         w_hist_wdata;
    t_hist_row         w_hist_row;

    t_mac_ctl          w_mac_ctl;
    t_sample           w_mac_data;
    logic              w_y_vld;
    t_sample           w_y;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_load  = (r_state == ST_DONE) && (!r_out_vld || o_out.ready);
    assign w_sec_done  = (r_state == ST_WAIT) && w_y_vld;

    // right channel rows follow the left channel rows
    assign w_hrow = HROW_W'(r_band) + (r_ch ? HROW_RIGHT : '0);

    // ---------------------------------------------------------------- stores
    // Coefficient writes land at the accept edge; the sweep writes
    // pass-through rows for the first NUM_BANDS counts after reset.
    always_comb begin
        w_coef_wr.init = (r_state == ST_SWEEP) && r_sweep_coef
                         && (32'(r_sweep_cnt) < NUM_BANDS);
        w_coef_wr.en   = w_accept && (i_in.cmd == CMD_COEF)
                         && (32'(i_in.band) < NUM_BANDS)
                         && (i_in.coef_select <= SEL_A2);
        w_coef_wr.sel  = i_in.coef_select;
        w_coef_wr.data = i_in.coef_value;
        w_coef_waddr   = (r_state == ST_SWEEP) ? BAND_W'(r_sweep_cnt)
                                               : BAND_W'(i_in.band);
    end

    sbeq_coef_ram #(
        .NUM_BANDS (NUM_BANDS),
        .BAND_W    (BAND_W)
    ) u_coef_ram (
        .i_clk     (i_clk),
        .i_wr      (w_coef_wr),
        .i_wr_addr (w_coef_waddr),
        .i_rd_en   (r_state == ST_RD),
        .i_rd_addr (r_band),
        .o_rd_row  (w_coef_row)
    );

    // Shift the history: x2 takes old x1, x1 the section input,
    // y2 takes old y1, y1 the section output. Sweep writes zero rows.
    always_comb begin
        w_hist_we    = (r_state == ST_SWEEP) || w_sec_done;
        w_hist_waddr = (r_state == ST_SWEEP) ? r_sweep_cnt : w_hrow;
        if (r_state == ST_SWEEP) begin
            w_hist_wdata = '0;
        end else begin
            w_hist_wdata.x1 = r_smp[r_ch];
            w_hist_wdata.x2 = w_hist_row.x1;
            w_hist_wdata.y1 = w_y;
            w_hist_wdata.y2 = w_hist_row.y1;
        end
    end

    sbeq_hist_ram #(
        .DEPTH  (HROWS),
        .ADDR_W (HROW_W)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_hist_waddr),
        .i_wdata (w_hist_wdata),
        .i_re    (r_state == ST_RD),
        .i_raddr (w_hrow),
        .o_rdata (w_hist_row)
    );

    // ------------------------------------------------------------- MAC unit
    // Term order: b0*x, b1*x1, b2*x2, then subtract a1*y1 and a2*y2.
    always_comb begin
        w_mac_ctl.vld   = (r_state == ST_MAC);
        w_mac_ctl.first = (r_term == TERM_X);
        w_mac_ctl.last  = (r_term == TERM_LAST);
        w_mac_ctl.neg   = (r_term >= TERM_Y1);
        case (r_term)
            TERM_X:  w_mac_data = r_smp[r_ch];
            TERM_X1: w_mac_data = w_hist_row.x1;
            TERM_X2: w_mac_data = w_hist_row.x2;
            TERM_Y1: w_mac_data = w_hist_row.y1;
            default: w_mac_data = w_hist_row.y2;
        endcase
    end

    sbeq_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_coef  (w_coef_row[r_term]),
        .i_data  (w_mac_data),
        .o_y_vld (w_y_vld),
        .o_y     (w_y)
    );

    // ------------------------------------------------------------ sequencer
    always_comb begin
        n_state      = r_state;
        n_sweep_cnt  = r_sweep_cnt;
        n_sweep_coef = r_sweep_coef;
        n_band       = r_band;
        n_ch         = r_ch;
        n_term       = r_term;
        n_out_vld    = r_out_vld;

        // drop the output beat once taken
        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_SWEEP: begin
                n_sweep_cnt = r_sweep_cnt + 1'b1;
                if (r_sweep_cnt == LAST_HROW) begin
                    n_state      = ST_IDLE;
                    n_sweep_cnt  = '0;
                    n_sweep_coef = 1'b0;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in.cmd)
                        CMD_FRAME: begin
                            n_band  = '0;
                            n_ch    = 1'b0;
                            n_state = r_enable ? ST_RD : ST_DONE;
                        end
                        CMD_CLEAR: begin
                            n_sweep_cnt  = '0;
                            n_sweep_coef = 1'b0;
                            n_state      = ST_SWEEP;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD: begin
                n_term  = TERM_X;
                n_state = ST_MAC;
            end
            ST_MAC: begin
                n_term = r_term + 1'b1;
                if (r_term == TERM_LAST) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_y_vld) begin
                    // advance: left then right of a band, then the next band
                    n_ch = ~r_ch;
                    if (r_ch) begin
                        n_band = r_band + 1'b1;
                    end
                    if (r_ch && (r_band == LAST_BAND)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_cnt  <= '0;
            r_sweep_coef <= 1'b1;
            r_band       <= '0;
            r_ch         <= 1'b0;
            r_term       <= '0;
            r_enable     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_cnt  <= n_sweep_cnt;
            r_sweep_coef <= n_sweep_coef;
            r_band       <= n_band;
            r_ch         <= n_ch;
            r_term       <= n_term;
            r_out_vld    <= n_out_vld;
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
        end
    end

    // running samples: hold the frame, replace with each section output
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in.cmd == CMD_FRAME)) begin
            r_smp[0] <= i_in.left_in;
            r_smp[1] <= i_in.right_in;
        end else if (w_sec_done) begin
            r_smp[r_ch] <= w_y;
        end
        if (w_out_load) begin
            r_out_l <= r_smp[0];
            r_out_r <= r_smp[1];
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.left_out  = r_out_l;
    assign o_out.right_out = r_out_r;

endmodule : stereo_biquad_cascade_equalizer
`default_nettype wire

/* tb/sbeq_eq_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// sbeq_eq_checker - scoreboard for the stereo biquad equalizer
// Watches the command and result channels and keeps its own copy of the
// coefficients, the section history and the enable bit. It predicts each
// output frame and compares it, field by field, with the next output beat.
// ============================================================================
module sbeq_eq_checker import sbeq_pkg::*; #(
    parameter int NUM_BANDS = 15
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    sbeq_in_if        i_in_mon,
    sbeq_out_if       i_out_mon,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        t_sample left;
        t_sample right;
    } t_stereo_frame;

    t_coef         band_coefs [NUM_BANDS][COEF_PER_BAND];
    t_hist_row     band_hist  [2][NUM_BANDS];
    logic          filter_on;
    t_stereo_frame frames_due [$];
    int            mismatches = 0;

    function automatic void clear_history();
        for (int ch = 0; ch < 2; ch++)
            for (int b = 0; b < NUM_BANDS; b++)
                band_hist[ch][b] = '0;
    endfunction

    // one direct-form-I section; exact sum, round half up, saturate
    function automatic t_sample run_biquad(int ch, int b, t_sample x);
        longint    acc;
        longint    y;
        t_hist_row h;
        h   = band_hist[ch][b];
        acc = longint'(band_coefs[b][SEL_B0]) * longint'(x)
            + longint'(band_coefs[b][SEL_B1]) * longint'(h.x1)
            + longint'(band_coefs[b][SEL_B2]) * longint'(h.x2)
            - longint'(band_coefs[b][SEL_A1]) * longint'(h.y1)
            - longint'(band_coefs[b][SEL_A2]) * longint'(h.y2);
        y = (acc + RND_HALF) >>> FRAC_SHIFT;
        if (y > SAMPLE_MAX) y = SAMPLE_MAX;
        if (y < SAMPLE_MIN) y = SAMPLE_MIN;
        h.x2 = h.x1;
        h.x1 = x;
        h.y2 = h.y1;
        h.y1 = t_sample'(y);
        band_hist[ch][b] = h;
        return t_sample'(y);
    endfunction

    function automatic t_stereo_frame equalize_frame(t_sample l, t_sample r);
        t_stereo_frame f;
        f.left  = l;
        f.right = r;
        if (filter_on) begin
            for (int b = 0; b < NUM_BANDS; b++) begin
                f.left  = run_biquad(0, b, f.left);
                f.right = run_biquad(1, b, f.right);
            end
        end
        return f;
    endfunction

    always @(posedge i_clk) begin : model
        t_stereo_frame want;
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BANDS; b++)
                for (int s = 0; s < COEF_PER_BAND; s++)
                    band_coefs[b][s] = (s == SEL_B0) ? t_coef'(COEF_ONE) : '0;
            clear_history();
            filter_on = 1'b0;
            frames_due.delete();
        end else begin
            if (i_cfg_we)
                filter_on = i_cfg_wdata;

            // check the result beat first: it can only belong to an older frame
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (frames_due.size() == 0) begin
                    $error("unexpected output beat: left_out %0d, right_out %0d",
                           i_out_mon.left_out, i_out_mon.right_out);
                    mismatches++;
                end else begin
                    want = frames_due.pop_front();
                    if (i_out_mon.left_out !== want.left) begin
                        $error("left_out mismatch: expected %0d, actual %0d",
                               want.left, i_out_mon.left_out);
                        mismatches++;
                    end
                    if (i_out_mon.right_out !== want.right) begin
                        $error("right_out mismatch: expected %0d, actual %0d",
                               want.right, i_out_mon.right_out);
                        mismatches++;
                    end
                end
            end

            if (i_in_mon.valid && i_in_mon.ready) begin
                case (i_in_mon.cmd)
                    CMD_FRAME: begin
                        frames_due.push_back(
                            equalize_frame(i_in_mon.left_in, i_in_mon.right_in));
                    end
                    CMD_COEF: begin
                        if (int'(i_in_mon.band) < NUM_BANDS &&
                            int'(i_in_mon.coef_select) < COEF_PER_BAND)
                            band_coefs[i_in_mon.band][i_in_mon.coef_select] =
                                i_in_mon.coef_value;
                    end
                    CMD_CLEAR: begin
                        clear_history();
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= frames_due.size();
    end

endmodule : sbeq_eq_checker

/* tb/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb - top level test of the stereo biquad cascade equalizer
// Drives commands, coefficient writes, history clears and stereo frames with
// random gaps and output stalls, toggles the enable bit between phases and
// leaves prediction and comparison to the scoreboard beside the block.
// ============================================================================
module tb;
    import sbeq_pkg::*;

    localparam int NUM_BANDS     = 15;
    // clear sweep is the longest command that leaves no result behind
    localparam int SETTLE_CYCLES = 2 * NUM_BANDS + 10;
    // one enabled frame plus margin, to catch a stray late beat
    localparam int END_CYCLES    = 18 * NUM_BANDS + 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [SEL_W-1:0] SEL_BAD_LO = 3'd5;
    localparam logic [SEL_W-1:0] SEL_BAD_HI = 3'd7;
    localparam logic [BAND_FIELD_W-1:0] BAND_BAD = 4'hF;

    localparam t_coef COEF_MAX = t_coef'(16777215);
    localparam t_coef COEF_MIN = t_coef'(-16777216);

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   fail_count;
    int   pending_frames;

    // burst flags switch off the random gaps for a while on each side
    bit   send_burst    = 1'b0;
    bit   recv_burst    = 1'b0;
    bit   hold_off_req  = 1'b0;

    sbeq_in_if  eq_in ();
    sbeq_out_if eq_out ();

    stereo_biquad_cascade_equalizer #(
        .NUM_BANDS (NUM_BANDS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (eq_in),
        .o_out       (eq_out)
    );

    sbeq_eq_checker #(
        .NUM_BANDS (NUM_BANDS)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_mon     (eq_in),
        .i_out_mon    (eq_out),
        .o_fail_count (fail_count),
        .o_pending    (pending_frames)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Offer one beat after a random gap and hold it until accepted. Valid
    // stays high on return, so a back-to-back beat never drops it.
    task automatic send_beat(
        input logic [CMD_W-1:0]        cmd,
        input t_sample                 left,
        input t_sample                 right,
        input logic [BAND_FIELD_W-1:0] band,
        input logic [SEL_W-1:0]        sel,
        input t_coef                   value
    );
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            eq_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        eq_in.valid       <= 1'b1;
        eq_in.cmd         <= cmd;
        eq_in.left_in     <= left;
        eq_in.right_in    <= right;
        eq_in.band        <= band;
        eq_in.coef_select <= sel;
        eq_in.coef_value  <= value;
        do @(posedge clk); while (!eq_in.ready);
    endtask

    // unused fields carry noise: the block must ignore them
    task automatic send_frame(input t_sample left, input t_sample right);
        send_beat(CMD_FRAME, left, right, BAND_FIELD_W'($urandom),
                  SEL_W'($urandom), t_coef'($urandom));
    endtask

    task automatic send_coef(
        input logic [BAND_FIELD_W-1:0] band,
        input logic [SEL_W-1:0]        sel,
        input t_coef                   value
    );
        send_beat(CMD_COEF, t_sample'($urandom), t_sample'($urandom), band, sel, value);
    endtask

    task automatic send_noise_cmd(input logic [CMD_W-1:0] cmd);
        send_beat(cmd, t_sample'($urandom), t_sample'($urandom),
                  BAND_FIELD_W'($urandom), SEL_W'($urandom), t_coef'($urandom));
    endtask

    // Drop valid and hold until every predicted frame has come out. The count
    // is sampled past a clock edge, so a frame accepted at that edge is counted.
    task automatic wait_drained();
        eq_in.valid <= 1'b0;
        do @(posedge clk); while (pending_frames != 0);
    endtask

    // Write enable only with the block idle: drain, then let a trailing
    // clear or coefficient write finish.
    task automatic set_enable(input logic value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random traffic. Most coefficient writes land in range with values near
    // a gentle filter so the cascade keeps doing real work; the rest use the
    // full fields, out-of-range bands and selectors included.
    task automatic run_random(input int n_items, input bit pause_midway,
                              input bit hold_midway);
        int                      roll;
        int                      span;
        int                      base;
        logic [BAND_FIELD_W-1:0] band;
        logic [SEL_W-1:0]        sel;
        t_coef                   value;
        for (int i = 0; i < n_items; i++) begin
            // ask the result side for a long hold-off while beats keep coming
            if (hold_midway && i == n_items / 4)
                hold_off_req = 1'b1;
            if (pause_midway && i == n_items / 2)
                wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                if ($urandom_range(0, 1) == 1)
                    send_frame(t_sample'($urandom), t_sample'($urandom));
                else
                    send_frame(t_sample'(int'($urandom_range(0, 524287)) - 262144),
                               t_sample'(int'($urandom_range(0, 524287)) - 262144));
            end else if (roll < 85) begin
                if ($urandom_range(0, 6) != 0) begin
                    band = BAND_FIELD_W'($urandom_range(0, NUM_BANDS - 1));
                    sel  = SEL_W'($urandom_range(0, COEF_PER_BAND - 1));
                end else begin
                    band = BAND_FIELD_W'($urandom);
                    sel  = SEL_W'($urandom);
                end
                if ($urandom_range(0, 4) == 0) begin
                    value = t_coef'($urandom);
                end else begin
                    span  = (sel == SEL_A1 || sel == SEL_A2) ? 524288 : 1048576;
                    base  = (sel == SEL_B0) ? COEF_ONE : 0;
                    value = t_coef'(base + int'($urandom_range(0, 2 * span)) - span);
                end
                send_coef(band, sel, value);
            end else if (roll < 94) begin
                send_noise_cmd(CMD_CLEAR);
            end else begin
                send_noise_cmd(CMD_UNUSED);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall per beat, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        int stall;
        eq_out.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                eq_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                eq_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            eq_out.ready <= 1'b1;
            do @(posedge clk); while (!eq_out.valid);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: give up after a long run of edges with no beat on any channel
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((eq_in.valid && eq_in.ready) || (eq_out.valid && eq_out.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("stereo_biquad_cascade_equalizer test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= 1'b0;
        eq_in.valid       <= 1'b0;
        eq_in.cmd         <= CMD_FRAME;
        eq_in.left_in     <= '0;
        eq_in.right_in    <= '0;
        eq_in.band        <= '0;
        eq_in.coef_select <= SEL_B0;
        eq_in.coef_value  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Disabled after reset: frames pass unchanged, unused command is a no-op.
        // Ready stays low through the store sweep; the first beat just waits.
        send_frame(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MIN));
        send_frame(t_sample'(SAMPLE_MIN), t_sample'(SAMPLE_MAX));
        send_frame('0, t_sample'(-1));
        send_noise_cmd(CMD_UNUSED);

        // Enabled with reset coefficients: every section is pass-through.
        set_enable(1'b1);
        send_frame(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MIN));
        send_frame(t_sample'(SAMPLE_MIN), t_sample'(1));

        // Writes to a band past the last section or with a bad selector drop.
        send_coef(BAND_BAD, SEL_B0, '0);
        send_coef('0, SEL_BAD_LO, '0);
        send_coef('0, SEL_BAD_HI, '0);

        // Largest gain in the first section: full-scale input must saturate.
        send_coef('0, SEL_B0, COEF_MAX);
        send_frame(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MIN));
        send_frame(t_sample'(1048576), t_sample'(-1048576));

        // Touch the remaining selectors; a1 feedback at the most negative coefficient.
        send_coef(4'd7, SEL_B1, t_coef'(2097152));
        send_coef(4'd7, SEL_B2, t_coef'(-1));
        send_coef(4'd14, SEL_A1, COEF_MIN);
        send_coef(4'd14, SEL_A2, t_coef'(COEF_ONE));
        send_frame(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MIN));
        send_frame(t_sample'(-5), t_sample'(7));
        send_frame('0, '0);

        // Clear history, then one frame from a clean start.
        send_noise_cmd(CMD_CLEAR);
        send_frame(t_sample'(1234567), t_sample'(-7654321));

        // Undo the runaway feedback and the big gain before random traffic.
        send_coef(4'd14, SEL_A1, '0);
        send_coef(4'd14, SEL_A2, '0);
        send_coef('0, SEL_B0, t_coef'(COEF_ONE));

        // Random phases, alternating enable. A mid-phase drain and a long
        // result-side hold-off land in some of them; disabled frames run
        // fast, so that phase fills the block and stalls its input.
        run_random(350, 1'b1, 1'b0);
        set_enable(1'b0);
        run_random(150, 1'b0, 1'b1);
        set_enable(1'b1);
        run_random(350, 1'b1, 1'b1);
        set_enable(1'b0);
        run_random(100, 1'b0, 1'b0);

        // Drain, then idle long enough to catch any stray result beat.
        wait_drained();
        repeat (END_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("stereo_biquad_cascade_equalizer test passed");
        else
            $display("stereo_biquad_cascade_equalizer test failed");
        $finish;
    end

endmodule : tb
